/* rtl/nfchd_pkg.sv */
package nfchd_pkg;

  localparam int unsigned MaxFrameBytes = 512;
  localparam int unsigned MinTimeoutMs  = 50;
  localparam int unsigned NormalOverhead = 7;
  localparam int unsigned ExtOverhead    = 10;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpTick  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PhIdle       = 3'd0,
    PhHunt       = 3'd1,
    PhHeader     = 3'd2,
    PhExtLen     = 3'd3,
    PhNormalBody = 3'd4,
    PhExtBody    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    StBusy     = 3'd0,
    StAck      = 3'd1,
    StNormal   = 3'd2,
    StExtended = 3'd3,
    StTimeout  = 3'd4,
    StTooLarge = 3'd5,
    StBad      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    ResNone  = 2'd0,
    ResOne   = 2'd1,
    ResStart = 2'd2
  } res_kind_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       frame_end;
    logic [2:0] status;
    logic [9:0] frame_length;
  } rsp_t;

  typedef struct packed {
    res_kind_e kind;
    rsp_t      rsp;
  } res_t;

endpackage

/* rtl/nfchd_if.sv */
interface nfchd_in_if ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [15:0] timeout_ms;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output timeout_ms, output rx_byte,
                  input ready);
  modport sink (input valid, input operation, input timeout_ms, input rx_byte,
                output ready);
endinterface

interface nfchd_out_if ();
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] frame_byte;
  logic [8:0] byte_index;
  logic       frame_end;
  logic [2:0] status;
  logic [9:0] frame_length;

  modport source (output valid, output has_byte, output frame_byte, output byte_index,
                  output frame_end, output status, output frame_length, input ready);
  modport sink (input valid, input has_byte, input frame_byte, input byte_index,
                input frame_end, input status, input frame_length, output ready);
endinterface

/* rtl/nfc_host_frame_deframer.sv */
// path: an item passes the input register, then the result register
// throughput: one item per cycle while the output is ready; the byte that
// completes the start code holds the result register for all three bytes
// reset: rst_ni low clears the receiver to idle and empties both the input
// register and the result register
module nfc_host_frame_deframer import nfchd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  nfchd_in_if.sink   item_i,
  nfchd_out_if.source result_o
);

  logic        in_valid_q;
  logic [1:0]  op_q;
  logic [15:0] tmo_q;
  logic [7:0]  byte_q;
  logic        free;
  logic        fire;
  logic        take;
  res_t        res;

  assign fire         = in_valid_q && free;
  assign item_i.ready = !in_valid_q || fire;
  assign take         = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= item_i.operation;
      tmo_q  <= item_i.timeout_ms;
      byte_q <= item_i.rx_byte;
    end
  end

  nfchd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (op_q),
    .tmo_i  (tmo_q),
    .byte_i (byte_q),
    .res_o  (res)
  );

  nfchd_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (free),
    .out_o  (result_o)
  );

endmodule

/* rtl/nfchd_core.sv */
module nfchd_core import nfchd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] tmo_i,
  input  logic [7:0]  byte_i,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  sync_q, sync_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [15:0] ms_q, ms_d;
  logic [15:0] len_q, len_d;
  logic [15:0] hdr_q, hdr_d;
  logic [7:0]  sum_q, sum_d;
  logic [9:0]  exp_q, exp_d;

  logic [15:0] ms_dec;
  logic [9:0]  cnt_inc;
  logic [7:0]  h3, h4;
  logic [16:0] norm_total, ext_total;
  logic [7:0]  lcs_sum;

  assign ms_dec     = (ms_q != 16'd0) ? ms_q - 16'd1 : 16'd0;
  assign cnt_inc    = cnt_q + 10'd1;
  assign h3         = hdr_q[15:8];
  assign h4         = hdr_q[7:0];
  assign norm_total = {9'd0, h3} + 17'(NormalOverhead);
  assign ext_total  = {1'b0, len_q} + 17'(ExtOverhead);
  assign lcs_sum    = len_q[7:0] + h4;

  always_comb begin
    phase_d = phase_q;
    sync_d  = sync_q;
    cnt_d   = cnt_q;
    ms_d    = ms_q;
    len_d   = len_q;
    hdr_d   = hdr_q;
    sum_d   = sum_q;
    exp_d   = exp_q;

    res_o.kind             = ResNone;
    res_o.rsp.has_byte     = 1'b1;
    res_o.rsp.frame_byte   = byte_i;
    res_o.rsp.byte_index   = cnt_q[8:0];
    res_o.rsp.frame_end    = 1'b0;
    res_o.rsp.status       = StBusy;
    res_o.rsp.frame_length = cnt_inc;

    if (fire_i) begin
      if (op_i == OpStart) begin
        phase_d = PhHunt;
        sync_d  = 2'd0;
        cnt_d   = 10'd0;
        len_d   = 16'd0;
        hdr_d   = 16'd0;
        sum_d   = 8'd0;
        exp_d   = 10'd0;
        ms_d    = (tmo_i < 16'(MinTimeoutMs)) ? 16'(MinTimeoutMs) : tmo_i;
      end else if (op_i == OpTick && phase_q != PhIdle) begin
        ms_d = ms_dec;
        if (ms_dec == 16'd0) begin
          phase_d                = PhIdle;
          res_o.kind             = ResOne;
          res_o.rsp.has_byte     = 1'b0;
          res_o.rsp.frame_byte   = 8'd0;
          res_o.rsp.byte_index   = 9'd0;
          res_o.rsp.frame_end    = 1'b1;
          res_o.rsp.status       = StTimeout;
          res_o.rsp.frame_length = cnt_q;
        end
      end else if (op_i == OpByte && phase_q == PhHunt) begin
        if (sync_q >= 2'd2 && byte_i == 8'hFF) begin
          res_o.kind = ResStart;
          cnt_d      = 10'd3;
          sync_d     = 2'd0;
          phase_d    = PhHeader;
        end else if (byte_i == 8'h00) begin
          sync_d = (sync_q >= 2'd1) ? 2'd2 : 2'd1;
        end else begin
          sync_d = 2'd0;
        end
      end else if (op_i == OpByte && phase_q != PhIdle) begin
        res_o.kind = ResOne;
        cnt_d      = cnt_inc;
        unique case (phase_q)
          PhHeader: begin
            if (cnt_q == 10'd3) begin
              hdr_d = {byte_i, 8'd0};
            end else if (cnt_q == 10'd4) begin
              hdr_d = {hdr_q[15:8], byte_i};
            end else if (h3 == 8'h00 && h4 == 8'hFF && byte_i == 8'h00) begin
              res_o.rsp.frame_end = 1'b1;
              res_o.rsp.status    = StAck;
            end else if (h3 == 8'hFF && h4 == 8'hFF) begin
              len_d   = {byte_i, 8'd0};
              phase_d = PhExtLen;
            end else begin
              len_d = {8'd0, h3};
              if (norm_total > 17'(MaxFrameBytes)) begin
                res_o.rsp.frame_end = 1'b1;
                res_o.rsp.status    = StTooLarge;
              end else begin
                exp_d   = norm_total[9:0];
                sum_d   = byte_i;
                phase_d = PhNormalBody;
              end
            end
          end
          PhExtLen: begin
            if (cnt_q == 10'd6) begin
              len_d = {len_q[15:8], byte_i};
            end else if (cnt_q >= 10'd8) begin
              if (ext_total > 17'(MaxFrameBytes)) begin
                res_o.rsp.frame_end = 1'b1;
                res_o.rsp.status    = StTooLarge;
              end else begin
                exp_d   = ext_total[9:0];
                phase_d = PhExtBody;
              end
            end
          end
          PhNormalBody: begin
            if (cnt_inc >= exp_q) begin
              res_o.rsp.frame_end = 1'b1;
              if (lcs_sum == 8'h00 && sum_q == 8'h00 && byte_i == 8'h00 &&
                  len_q != 16'd0) begin
                res_o.rsp.status = StNormal;
              end else begin
                res_o.rsp.status = StBad;
              end
            end else begin
              sum_d = sum_q + byte_i;
            end
          end
          PhExtBody: begin
            if (cnt_inc >= exp_q) begin
              res_o.rsp.frame_end = 1'b1;
              res_o.rsp.status    = StExtended;
            end
          end
          default: begin
          end
        endcase
        if (res_o.rsp.frame_end) begin
          phase_d = PhIdle;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      sync_q  <= 2'd0;
      cnt_q   <= 10'd0;
      ms_q    <= 16'd0;
      len_q   <= 16'd0;
      hdr_q   <= 16'd0;
      sum_q   <= 8'd0;
      exp_q   <= 10'd0;
    end else begin
      phase_q <= phase_d;
      sync_q  <= sync_d;
      cnt_q   <= cnt_d;
      ms_q    <= ms_d;
      len_q   <= len_d;
      hdr_q   <= hdr_d;
      sum_q   <= sum_d;
      exp_q   <= exp_d;
    end
  end

endmodule

/* rtl/nfchd_outq.sv */
module nfchd_outq import nfchd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_t        res_i,
  output logic        free_o,
  nfchd_out_if.source out_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [1:0] pos_q, pos_d;
  logic       start_q, start_d;
  rsp_t       rsp_q, rsp_d;
  rsp_t       cur;
  logic       pop;

  assign pop    = out_o.valid && out_o.ready;
  assign free_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);

  always_comb begin
    if (start_q) begin
      cur.has_byte     = 1'b1;
      cur.frame_byte   = (pos_q == 2'd2) ? 8'hFF : 8'h00;
      cur.byte_index   = {7'd0, pos_q};
      cur.frame_end    = 1'b0;
      cur.status       = StBusy;
      cur.frame_length = {8'd0, pos_q} + 10'd1;
    end else begin
      cur = rsp_q;
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    start_d = start_q;
    rsp_d   = rsp_q;
    if (pop) begin
      cnt_d = cnt_q - 2'd1;
      pos_d = pos_q + 2'd1;
    end
    if (load_i && res_i.kind == ResStart) begin
      cnt_d   = 2'd3;
      pos_d   = 2'd0;
      start_d = 1'b1;
    end else if (load_i && res_i.kind == ResOne) begin
      cnt_d   = 2'd1;
      pos_d   = 2'd0;
      start_d = 1'b0;
      rsp_d   = res_i.rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      pos_q   <= 2'd0;
      start_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.has_byte     = cur.has_byte;
  assign out_o.frame_byte   = cur.frame_byte;
  assign out_o.byte_index   = cur.byte_index;
  assign out_o.frame_end    = cur.frame_end;
  assign out_o.status       = cur.status;
  assign out_o.frame_length = cur.frame_length;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import nfchd_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int RandomItems = 110;
  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 8;
  localparam int ReportLimit = 10;

  typedef enum int {FlawNone, FlawLcs, FlawDcs, FlawPostamble} flaw_e;
  typedef enum int {SinkOpen, SinkCoin, SinkPeriodic, SinkBursty} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  nfchd_in_if in_if ();
  nfchd_out_if out_if ();

  nfc_host_frame_deframer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if)
  );

  // receiver model state
  phase_e      frame_phase;
  logic [1:0]  zero_run;
  logic [9:0]  captured;
  logic [15:0] ms_left;
  logic [15:0] len_field;
  logic [15:0] hdr;
  logic [7:0]  data_sum;
  logic [16:0] total_bytes;

  rsp_t       expected_q[$];
  logic [7:0] frame_q[$];
  int ending_tally[8];
  int items_sent = 0;
  int items_acted = 0;
  int results_seen = 0;
  int fault_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  sink_mode_e sink_mode = SinkOpen;
  int stall_left = 0;

  function automatic void clear_receiver();
    frame_phase = PhIdle;
    zero_run = '0;
    captured = '0;
    ms_left = '0;
    len_field = '0;
    hdr = '0;
    data_sum = '0;
    total_bytes = '0;
  endfunction

  function automatic void push_result(logic hb, logic [7:0] fb, logic [8:0] idx, logic fin,
                                      status_e st, logic [9:0] flen);
    rsp_t r;
    r.has_byte = hb;
    r.frame_byte = fb;
    r.byte_index = idx;
    r.frame_end = fin;
    r.status = st;
    r.frame_length = flen;
    expected_q.push_back(r);
    if (fin) ending_tally[st]++;
  endfunction

  // returns 1 for a start, or for a byte or tick while the receiver is not idle
  function automatic bit predict_deframe(logic [1:0] op, logic [15:0] tmo, logic [7:0] rxb);
    logic [9:0] idx;
    logic       done;
    status_e    st;
    logic [7:0] h3;
    logic [7:0] h4;
    logic [7:0] lsum;
    done = 1'b0;
    st = StBusy;
    h3 = hdr[15:8];
    h4 = hdr[7:0];
    if (op == OpStart) begin
      clear_receiver();
      frame_phase = PhHunt;
      ms_left = (tmo < MinTimeoutMs) ? 16'(MinTimeoutMs) : tmo;
      return 1'b1;
    end
    if (frame_phase == PhIdle || !(op == OpByte || op == OpTick)) return 1'b0;
    if (op == OpTick) begin
      if (ms_left != 0) ms_left--;
      if (ms_left == 0) begin
        push_result(1'b0, 8'h00, 9'd0, 1'b1, StTimeout, captured);
        frame_phase = PhIdle;
      end
      return 1'b1;
    end
    if (frame_phase == PhHunt) begin
      if (zero_run >= 2 && rxb == 8'hFF) begin
        push_result(1'b1, 8'h00, 9'd0, 1'b0, StBusy, 10'd1);
        push_result(1'b1, 8'h00, 9'd1, 1'b0, StBusy, 10'd2);
        push_result(1'b1, 8'hFF, 9'd2, 1'b0, StBusy, 10'd3);
        captured = 10'd3;
        zero_run = '0;
        frame_phase = PhHeader;
      end else if (rxb == 8'h00) begin
        zero_run = (zero_run >= 1) ? 2'd2 : 2'd1;
      end else begin
        zero_run = '0;
      end
      return 1'b1;
    end
    idx = captured;
    captured++;
    case (frame_phase)
      PhHeader: begin
        if (idx == 10'd3) begin
          hdr = {rxb, 8'h00};
        end else if (idx == 10'd4) begin
          hdr[7:0] = rxb;
        end else if (h3 == 8'h00 && h4 == 8'hFF && rxb == 8'h00) begin
          done = 1'b1;
          st = StAck;
        end else if (h3 == 8'hFF && h4 == 8'hFF) begin
          len_field = {rxb, 8'h00};
          frame_phase = PhExtLen;
        end else begin
          len_field = {8'h00, h3};
          if (int'(h3) + NormalOverhead > MaxFrameBytes) begin
            done = 1'b1;
            st = StTooLarge;
          end else begin
            total_bytes = 17'(h3) + 17'(NormalOverhead);
            data_sum = rxb;
            frame_phase = PhNormalBody;
          end
        end
      end
      PhExtLen: begin
        if (idx == 10'd6) begin
          len_field[7:0] = rxb;
        end else if (idx >= 10'd8) begin
          if (int'(len_field) + ExtOverhead > MaxFrameBytes) begin
            done = 1'b1;
            st = StTooLarge;
          end else begin
            total_bytes = 17'(len_field) + 17'(ExtOverhead);
            frame_phase = PhExtBody;
          end
        end
      end
      PhNormalBody: begin
        if (17'(captured) >= total_bytes) begin
          lsum = len_field[7:0] + h4;
          done = 1'b1;
          st = (lsum == 8'h00 && data_sum == 8'h00 && rxb == 8'h00 && len_field >= 1) ?
               StNormal : StBad;
        end else begin
          data_sum = data_sum + rxb;
        end
      end
      default: begin
        if (17'(captured) >= total_bytes) begin
          done = 1'b1;
          st = StExtended;
        end
      end
    endcase
    push_result(1'b1, rxb, idx[8:0], done, st, captured);
    if (done) frame_phase = PhIdle;
    return 1'b1;
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] tmo, logic [7:0] rxb);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.timeout_ms <= tmo;
    in_if.rx_byte <= rxb;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (predict_deframe(op, tmo, rxb)) items_acted++;
  endtask

  task automatic send_frame_bytes();
    foreach (frame_q[i]) begin
      if ($urandom_range(0, 15) == 0) send_item(OpTick, 16'($urandom), 8'($urandom));
      send_item(OpByte, 16'($urandom), frame_q[i]);
    end
    frame_q.delete();
  endtask

  function automatic void queue_start_code(int noise);
    repeat (noise) frame_q.push_back(8'($urandom_range(1, 255)));
    repeat ($urandom_range(2, 4)) frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
  endfunction

  function automatic void queue_normal(int len, flaw_e flaw);
    logic [7:0] lcs;
    logic [7:0] sum;
    logic [7:0] d;
    lcs = 8'h00 - 8'(len);
    if (flaw == FlawLcs) lcs = lcs + 8'($urandom_range(1, 255));
    frame_q.push_back(8'(len));
    frame_q.push_back(lcs);
    sum = 8'h00;
    repeat (len) begin
      d = 8'($urandom);
      frame_q.push_back(d);
      sum = sum + d;
    end
    sum = 8'h00 - sum;
    if (flaw == FlawDcs) sum = sum + 8'($urandom_range(1, 255));
    frame_q.push_back(sum);
    frame_q.push_back((flaw == FlawPostamble) ? 8'($urandom_range(1, 255)) : 8'h00);
  endfunction

  function automatic void queue_extended(int len);
    logic [15:0] l16;
    l16 = 16'(len);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'hFF);
    frame_q.push_back(l16[15:8]);
    frame_q.push_back(l16[7:0]);
    frame_q.push_back(8'h00 - l16[15:8] - l16[7:0]);
    if (len + ExtOverhead > MaxFrameBytes) frame_q.push_back(8'($urandom));
    else repeat (len + 2) frame_q.push_back(8'($urandom));
  endfunction

  task automatic test_idle_items();
    send_item(OpByte, 16'hFFFF, 8'hFF);
    send_item(OpTick, 16'h0000, 8'h00);
    send_item(OpUnused, 16'hA5A5, 8'h5A);
  endtask

  task automatic test_ack_with_long_preamble();
    send_item(OpStart, 16'h0000, 8'h00);
    frame_q = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    send_frame_bytes();
  endtask

  task automatic test_rearm_and_normal_frame();
    send_item(OpStart, 16'h1234, 8'h00);
    frame_q = '{8'h00, 8'h00, 8'hFF, 8'h03};
    send_frame_bytes();
    send_item(OpStart, 16'hFFFF, 8'hFF);
    frame_q = '{8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'hD4, 8'h2C, 8'h00};
    send_frame_bytes();
  endtask

  task automatic test_oversize_extended();
    send_item(OpStart, 16'hFFFF, 8'h00);
    frame_q = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hF7, 8'h08, 8'hFF};
    send_frame_bytes();
  endtask

  task automatic test_timeout();
    send_item(OpStart, 16'd10, 8'h00);
    frame_q = '{8'h00, 8'h00, 8'hFF, 8'h02};
    send_frame_bytes();
    while (frame_phase != PhIdle) send_item(OpTick, 16'($urandom), 8'($urandom));
    send_item(OpTick, 16'h0000, 8'h00);
  endtask

  task automatic test_long_frames();
    send_item(OpStart, 16'hFFFF, 8'h00);
    queue_start_code(0);
    queue_extended(16);
    send_frame_bytes();
    send_item(OpStart, 16'hFFFF, 8'h00);
    queue_start_code(1);
    queue_normal(32, FlawNone);
    send_frame_bytes();
  endtask

  task automatic test_random_traffic();
    int base;
    int pick;
    int len;
    flaw_e flaw;
    base = items_acted;
    while (items_acted - base < RandomItems) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 9) != 0 && pick < 96)
        send_item(OpStart, 16'($urandom), 8'($urandom));
      if (pick < 12) begin
        queue_start_code($urandom_range(0, 2));
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h00);
      end else if (pick < 45) begin
        queue_start_code($urandom_range(0, 2));
        queue_normal(len, FlawNone);
      end else if (pick < 60) begin
        queue_start_code($urandom_range(0, 2));
        flaw = flaw_e'($urandom_range(FlawLcs, FlawPostamble));
        if ($urandom_range(0, 3) == 0) queue_normal(0, FlawNone);
        else queue_normal(len, flaw);
      end else if (pick < 74) begin
        queue_start_code($urandom_range(0, 2));
        queue_extended($urandom_range(0, 6));
      end else if (pick < 80) begin
        queue_start_code($urandom_range(0, 2));
        queue_extended(($urandom_range(0, 3) == 0) ? 503 : $urandom_range(503, 65535));
      end else if (pick < 88) begin
        // frame cut short, the next start drops it
        queue_start_code($urandom_range(0, 2));
        queue_normal(len, FlawNone);
        len = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > len) void'(frame_q.pop_back());
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end else begin
        send_item(OpStart, 16'($urandom_range(0, 60)), 8'($urandom));
        queue_start_code(0);
        queue_normal(len, FlawNone);
        len = $urandom_range(0, frame_q.size() - 1);
        while (frame_q.size() > len) void'(frame_q.pop_back());
        send_frame_bytes();
        while (frame_phase != PhIdle) send_item(OpTick, 16'($urandom), 8'($urandom));
      end
      send_frame_bytes();
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 97 == 0) sink_mode = sink_mode_e'($urandom_range(0, 3));
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (sink_mode)
        SinkOpen: out_if.ready <= 1'b1;
        SinkCoin: out_if.ready <= 1'($urandom_range(0, 1));
        SinkPeriodic: out_if.ready <= (cycle_count % 3 == 0);
        default: begin
          out_if.ready <= 1'b1;
          if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(2, 14);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_result
    rsp_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        fault_count++;
        if (fault_count <= ReportLimit)
          $display({"unexpected result transaction: ",
                    "hb=%0d byte=%02h idx=%0d end=%0d st=%0d len=%0d"},
                   out_if.has_byte, out_if.frame_byte, out_if.byte_index, out_if.frame_end,
                   out_if.status, out_if.frame_length);
      end else begin
        want = expected_q.pop_front();
        if (out_if.has_byte !== want.has_byte || out_if.frame_byte !== want.frame_byte ||
            out_if.byte_index !== want.byte_index || out_if.frame_end !== want.frame_end ||
            out_if.status !== want.status || out_if.frame_length !== want.frame_length) begin
          fault_count++;
          if (fault_count <= ReportLimit) begin
            $display({"mismatch on result %0d: ",
                      "expected hb=%0d byte=%02h idx=%0d end=%0d st=%0d len=%0d"},
                     results_seen, want.has_byte, want.frame_byte, want.byte_index,
                     want.frame_end, want.status, want.frame_length);
            $display("  got hb=%0d byte=%02h idx=%0d end=%0d st=%0d len=%0d",
                     out_if.has_byte, out_if.frame_byte, out_if.byte_index, out_if.frame_end,
                     out_if.status, out_if.frame_length);
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.operation <= OpStart;
    in_if.timeout_ms <= '0;
    in_if.rx_byte <= '0;
    clear_receiver();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_items();
    test_ack_with_long_preamble();
    test_rearm_and_normal_frame();
    test_oversize_extended();
    test_timeout();
    test_long_frames();
    test_random_traffic();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d input transactions (%0d acted on), %0d result transactions, %0d mismatches",
             items_sent, items_acted, results_seen, fault_count);
    $display("frames ended: ack %0d, normal %0d, extended %0d, timeout %0d, too large %0d, bad %0d",
             ending_tally[StAck], ending_tally[StNormal], ending_tally[StExtended],
             ending_tally[StTimeout], ending_tally[StTooLarge], ending_tally[StBad]);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
